### hdl/bdq_pkg.sv
// Shared types and constants for the bounded deque with positional read.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int CAPACITY     = 256;
    localparam int PTR_BITS     = 8;
    localparam int COUNT_BITS   = 9;
    localparam int ELEMENT_BITS = 32;
    localparam int OP_BITS      = 3;
    localparam int STATUS_BITS  = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT_HEAD = 3'd0,
        OP_INSERT_TAIL = 3'd1,
        OP_REMOVE_HEAD = 3'd2,
        OP_REMOVE_TAIL = 3'd3,
        OP_READ_HEAD   = 3'd4,
        OP_READ_TAIL   = 3'd5,
        OP_READ_INDEX  = 3'd6,
        OP_SIZE        = 3'd7
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_RESULT
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

### hdl/bdq_controller.sv
// Controller state machine that sequences command capture, execution and result.
`timescale 1ns / 1ps

module bdq_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output bdq_pkg::ctl_cmd_t cmd
);

    bdq_pkg::ctl_state_t state_reg;
    bdq_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            bdq_pkg::CTL_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = bdq_pkg::CTL_EXEC;
                end
            end
            bdq_pkg::CTL_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = bdq_pkg::CTL_RESULT;
            end
            bdq_pkg::CTL_RESULT:
            begin
                // The result word is shown while the next command may be taken.
                done = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = bdq_pkg::CTL_EXEC;
                end
                else
                begin
                    state_next = bdq_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::CTL_IDLE;
            end
        endcase
    end

endmodule

### hdl/bdq_datapath.sv
// Datapath with the ring store, head pointer, element count and result registers.
`timescale 1ns / 1ps

module bdq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bdq_pkg::ctl_cmd_t                   cmd,
    input  logic [bdq_pkg::OP_BITS-1:0]         operation,
    input  logic [bdq_pkg::ELEMENT_BITS-1:0]    element_in,
    input  logic [bdq_pkg::PTR_BITS-1:0]        position,
    output logic [bdq_pkg::ELEMENT_BITS-1:0]    element_out,
    output logic [bdq_pkg::COUNT_BITS-1:0]      entry_count,
    output logic [bdq_pkg::STATUS_BITS-1:0]     status
);

    logic [bdq_pkg::ELEMENT_BITS-1:0] mem [bdq_pkg::CAPACITY];

    bdq_pkg::op_t                     op_reg;
    logic [bdq_pkg::ELEMENT_BITS-1:0] elem_reg;
    logic [bdq_pkg::PTR_BITS-1:0]     pos_reg;

    logic [bdq_pkg::PTR_BITS-1:0]     head_reg;
    logic [bdq_pkg::PTR_BITS-1:0]     head_next;
    logic [bdq_pkg::COUNT_BITS-1:0]   count_reg;
    logic [bdq_pkg::COUNT_BITS-1:0]   count_next;
    bdq_pkg::status_t                 status_reg;
    bdq_pkg::status_t                 status_next;
    logic                             hit_reg;
    logic                             hit_next;
    logic [bdq_pkg::ELEMENT_BITS-1:0] rd_data_reg;

    logic                             wr_en;
    logic [bdq_pkg::PTR_BITS-1:0]     addr;
    logic                             empty;
    logic                             full;
    logic [bdq_pkg::PTR_BITS-1:0]     count_low;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == bdq_pkg::COUNT_BITS'(bdq_pkg::CAPACITY));
    assign count_low = count_reg[bdq_pkg::PTR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= bdq_pkg::op_t'(operation);
            elem_reg <= element_in;
            pos_reg  <= position;
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = bdq_pkg::STS_DONE;
        hit_next    = 1'b0;
        wr_en       = 1'b0;
        addr        = head_reg;
        case (op_reg)
            bdq_pkg::OP_INSERT_HEAD:
            begin
                addr = head_reg - 1'b1;
                if (full)
                begin
                    status_next = bdq_pkg::STS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    head_next  = addr;
                    count_next = count_reg + 1'b1;
                end
            end
            bdq_pkg::OP_INSERT_TAIL:
            begin
                addr = head_reg + count_low;
                if (full)
                begin
                    status_next = bdq_pkg::STS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdq_pkg::OP_REMOVE_HEAD:
            begin
                if (empty)
                begin
                    status_next = bdq_pkg::STS_EMPTY;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            bdq_pkg::OP_REMOVE_TAIL:
            begin
                if (empty)
                begin
                    status_next = bdq_pkg::STS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            bdq_pkg::OP_READ_HEAD:
            begin
                if (empty)
                begin
                    status_next = bdq_pkg::STS_EMPTY;
                end
                else
                begin
                    hit_next = 1'b1;
                end
            end
            bdq_pkg::OP_READ_TAIL:
            begin
                addr = head_reg + count_low - 1'b1;
                if (empty)
                begin
                    status_next = bdq_pkg::STS_EMPTY;
                end
                else
                begin
                    hit_next = 1'b1;
                end
            end
            bdq_pkg::OP_READ_INDEX:
            begin
                addr = head_reg + pos_reg;
                if (empty)
                begin
                    status_next = bdq_pkg::STS_EMPTY;
                end
                else if ({1'b0, pos_reg} >= count_reg)
                begin
                    status_next = bdq_pkg::STS_RANGE;
                end
                else
                begin
                    hit_next = 1'b1;
                end
            end
            default:
            begin
                status_next = bdq_pkg::STS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (wr_en)
            begin
                mem[addr] <= elem_reg;
            end
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            status_reg <= bdq_pkg::STS_DONE;
            hit_reg    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    assign element_out = hit_reg ? rd_data_reg : '0;
    assign entry_count = count_reg;
    assign status      = status_reg;

endmodule

### hdl/bounded_deque_with_index_core.sv
// Top level of the bounded deque: controller and datapath joined by a command struct.
// Sequence: a command is captured when it is taken, executed in the EXEC state, and its
// result word is registered and shown on the outputs in the RESULT state, marked by done.
// Commands do not overlap: the execute state holds the single ring store port;
// a new command is taken while the result word is shown.
// Reset: rst_n clears the head pointer, the count and the controller; the store is not cleared.
`timescale 1ns / 1ps

module bounded_deque_with_index_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic [bdq_pkg::OP_BITS-1:0]         operation,
    input  logic [bdq_pkg::ELEMENT_BITS-1:0]    element_in,
    input  logic [bdq_pkg::PTR_BITS-1:0]        position,
    output logic [bdq_pkg::ELEMENT_BITS-1:0]    element_out,
    output logic [bdq_pkg::COUNT_BITS-1:0]      entry_count,
    output logic [bdq_pkg::STATUS_BITS-1:0]     status
);

    bdq_pkg::ctl_cmd_t cmd;

    bdq_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    bdq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (operation),
        .element_in  (element_in),
        .position    (position),
        .element_out (element_out),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule

### hdl/bdq_checker.sv
// Port-level checker for the bounded deque and the bind that attaches it.
`timescale 1ns / 1ps

module bdq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [bdq_pkg::ELEMENT_BITS-1:0]    element_out,
    input logic [bdq_pkg::COUNT_BITS-1:0]      entry_count,
    input logic [bdq_pkg::STATUS_BITS-1:0]     status
);

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("Accepted word was not followed by an execute cycle.");

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("Result word did not appear two cycles after acceptance.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != bdq_pkg::STS_DONE) |-> (element_out == '0))
        else $error("Failed operation returned a nonzero element.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bdq_pkg::STS_FULL)
            |-> (entry_count == bdq_pkg::COUNT_BITS'(bdq_pkg::CAPACITY)))
        else $error("Full status with a count below capacity.");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bdq_pkg::STS_EMPTY) |-> (entry_count == '0))
        else $error("Empty status with a nonzero count.");

endmodule

bind bounded_deque_with_index_core bdq_checker u_bdq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .element_out (element_out),
    .entry_count (entry_count),
    .status      (status)
);
